// ===== hw/rtl/nnds_pkg.sv =====
// Package for the nearest-neighbor downscaler: sizes, register indexes,
// the result item type and the size fitting function. No dependencies.
package nnds_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int REG_W   = 13;
  localparam int POS_W   = 12;
  localparam int CNT_W   = 13;
  localparam int ACC_W   = 25;
  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 4;

  localparam logic [INDEX_W-1:0] REG_SRC_WIDTH  = 4'd0;
  localparam logic [INDEX_W-1:0] REG_SRC_HEIGHT = 4'd1;
  localparam logic [INDEX_W-1:0] REG_DST_WIDTH  = 4'd2;
  localparam logic [INDEX_W-1:0] REG_DST_HEIGHT = 4'd3;

  localparam logic [REG_W-1:0] RST_SRC_WIDTH  = 13'd640;
  localparam logic [REG_W-1:0] RST_SRC_HEIGHT = 13'd480;
  localparam logic [REG_W-1:0] RST_DST_WIDTH  = 13'd320;
  localparam logic [REG_W-1:0] RST_DST_HEIGHT = 13'd240;

  localparam logic [REG_W-1:0] MAX_SIZE = REG_W'(MAX_DIMENSION);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic              frame_end;
  } res_t;

  // zero reads as one, then clamp to the maximum and to the cap
  function automatic logic [REG_W-1:0] fit_size(input logic [REG_W-1:0] v,
                                                input logic [REG_W-1:0] cap);
    logic [REG_W-1:0] r;
    r = (v == '0) ? REG_W'(1) : v;
    if (r > MAX_SIZE) r = MAX_SIZE;
    if (r > cap) r = cap;
    return r;
  endfunction

endpackage

// ===== hw/rtl/nnds_if.sv =====
// Channel interfaces of the downscaler: source pixels, results, config.
// Depends on nnds_pkg.
interface nnds_pix_if;
  import nnds_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface nnds_res_if;
  import nnds_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;
  logic [POS_W-1:0]  out_x;
  logic [POS_W-1:0]  out_y;
  logic              frame_end;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, out_x, out_y,
                  frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, out_x, out_y,
                frame_end, output ready);
endinterface

interface nnds_cfg_if;
  import nnds_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic [REG_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/nearest_neighbour_downscaler_core.sv =====
// Nearest-neighbor downscaler top level: front end, queue, output stage.
// Depends on nnds_pkg, nnds_if, nnds_front, nnds_queue, nnds_back.
//
// Takes one source pixel per clock in raster order and passes on the pixels
// that land on target sample positions, tagged with target column and row;
// the last target pixel of a frame has frame_end set. Sampling uses running
// sums, so one item is accepted every cycle with no divider; a sampled pixel
// passes through the front end, the four-entry queue and the output register
// on its way out. The input stalls only when the queue is full.
// Any config write to a known index restarts the frame. Sizes of zero count
// as one, sizes are capped at 4096, target sizes are clamped to source sizes.
module nearest_neighbour_downscaler_core (
  input  logic       clk,
  input  logic       rst,
  nnds_pix_if.sink   pix,
  nnds_cfg_if.sink   cfg,
  nnds_res_if.source res
);
  import nnds_pkg::*;

  res_t push_data, pop_data;
  logic push, full, pop, empty;

  nnds_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pix    (pix),
    .cfg    (cfg),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  nnds_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  nnds_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (empty),
    .q_data  (pop_data),
    .q_pop   (pop),
    .res     (res)
  );

endmodule

// ===== hw/rtl/nnds_front.sv =====
// Front end: size registers, position tracking and the sampling decision.
// Pushes sampled pixels into the queue. Depends on nnds_pkg, nnds_if.
module nnds_front (
  input  logic           clk,
  input  logic           rst,
  nnds_pix_if.sink       pix,
  nnds_cfg_if.sink       cfg,
  input  logic           q_full,
  output logic           q_push,
  output nnds_pkg::res_t q_data
);
  import nnds_pkg::*;

  logic [REG_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [REG_W-1:0] src_width_next, src_height_next, dst_width_next, dst_height_next;
  logic [REG_W-1:0] sw, sh, tw, th, sw_next, sh_next, tw_next, th_next;

  logic [POS_W-1:0] source_column, source_row;
  logic [CNT_W-1:0] target_column, target_row;
  logic [ACC_W-1:0] column_numerator, column_product, row_numerator, row_product;

  logic             pix_acc, cfg_acc, cfg_hit;
  logic             col_hit, row_hit, last_col, last_row;

  assign pix.ready = ~q_full;
  assign cfg.ready = 1'b1;
  assign pix_acc   = pix.valid & pix.ready;
  assign cfg_acc   = cfg.valid & cfg.ready;

  assign sw = fit_size(src_width, MAX_SIZE);
  assign sh = fit_size(src_height, MAX_SIZE);
  assign tw = fit_size(dst_width, sw);
  assign th = fit_size(dst_height, sh);

  always_comb begin
    src_width_next  = src_width;
    src_height_next = src_height;
    dst_width_next  = dst_width;
    dst_height_next = dst_height;
    cfg_hit         = 1'b1;
    case (cfg.index)
      REG_SRC_WIDTH:  src_width_next  = cfg.data;
      REG_SRC_HEIGHT: src_height_next = cfg.data;
      REG_DST_WIDTH:  dst_width_next  = cfg.data;
      REG_DST_HEIGHT: dst_height_next = cfg.data;
      default:        cfg_hit         = 1'b0;
    endcase
  end

  assign sw_next = fit_size(src_width_next, MAX_SIZE);
  assign sh_next = fit_size(src_height_next, MAX_SIZE);
  assign tw_next = fit_size(dst_width_next, sw_next);
  assign th_next = fit_size(dst_height_next, sh_next);

  assign col_hit  = (target_column < tw) &&
                    (column_numerator < column_product + ACC_W'(tw));
  assign row_hit  = (target_row < th) && (row_numerator < row_product + ACC_W'(th));
  assign last_col = ({1'b0, source_column} + CNT_W'(1)) >= sw;
  assign last_row = ({1'b0, source_row} + CNT_W'(1)) >= sh;

  assign q_push         = pix_acc & col_hit & row_hit;
  assign q_data.red       = pix.red;
  assign q_data.green     = pix.green;
  assign q_data.blue      = pix.blue;
  assign q_data.alpha     = pix.alpha;
  assign q_data.x         = target_column[POS_W-1:0];
  assign q_data.y         = target_row[POS_W-1:0];
  assign q_data.frame_end = (target_column == tw - REG_W'(1)) &&
                            (target_row == th - REG_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width        <= RST_SRC_WIDTH;
      src_height       <= RST_SRC_HEIGHT;
      dst_width        <= RST_DST_WIDTH;
      dst_height       <= RST_DST_HEIGHT;
      source_column    <= '0;
      source_row       <= '0;
      target_column    <= '0;
      target_row       <= '0;
      column_product   <= '0;
      row_product      <= '0;
      column_numerator <= ACC_W'(RST_DST_WIDTH >> 1);
      row_numerator    <= ACC_W'(RST_DST_HEIGHT >> 1);
    end else if (cfg_acc) begin
      if (cfg_hit) begin
        src_width        <= src_width_next;
        src_height       <= src_height_next;
        dst_width        <= dst_width_next;
        dst_height       <= dst_height_next;
        source_column    <= '0;
        source_row       <= '0;
        target_column    <= '0;
        target_row       <= '0;
        column_product   <= '0;
        row_product      <= '0;
        column_numerator <= ACC_W'(tw_next >> 1);
        row_numerator    <= ACC_W'(th_next >> 1);
      end
    end else if (pix_acc) begin
      if (last_col) begin
        source_column    <= '0;
        target_column    <= '0;
        column_product   <= '0;
        column_numerator <= ACC_W'(tw >> 1);
        if (last_row) begin
          source_row    <= '0;
          target_row    <= '0;
          row_product   <= '0;
          row_numerator <= ACC_W'(th >> 1);
        end else begin
          source_row  <= source_row + POS_W'(1);
          row_product <= row_product + ACC_W'(th);
          if (row_hit) begin
            target_row    <= target_row + CNT_W'(1);
            row_numerator <= row_numerator + ACC_W'(sh);
          end
        end
      end else begin
        source_column  <= source_column + POS_W'(1);
        column_product <= column_product + ACC_W'(tw);
        if (col_hit) begin
          target_column    <= target_column + CNT_W'(1);
          column_numerator <= column_numerator + ACC_W'(sw);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/nnds_queue.sv =====
// Small queue of sampled pixels between front and back end.
// Depends on nnds_pkg.
module nnds_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nnds_pkg::res_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output nnds_pkg::res_t pop_data
);
  import nnds_pkg::*;

  res_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/nnds_back.sv =====
// Back end: output register that drives the result channel from the queue.
// Depends on nnds_pkg, nnds_if.
module nnds_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  nnds_pkg::res_t q_data,
  output logic           q_pop,
  nnds_res_if.source     res
);
  import nnds_pkg::*;

  res_t out_reg;
  logic valid;

  assign q_pop = ~q_empty & (~valid | res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (~valid | res.ready) begin
      valid <= ~q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_reg <= q_data;
  end

  assign res.valid     = valid;
  assign res.out_red   = out_reg.red;
  assign res.out_green = out_reg.green;
  assign res.out_blue  = out_reg.blue;
  assign res.out_alpha = out_reg.alpha;
  assign res.out_x     = out_reg.x;
  assign res.out_y     = out_reg.y;
  assign res.frame_end = out_reg.frame_end;

endmodule
